### rtl/tckm_pkg.sv
// Shared types and constants for the two-cluster 1-D k-means core.
// Depends on nothing; used by the core and the testbench.
package tckm_pkg;

  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SUM_W      = 22;
  localparam int unsigned ITER_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_STEP_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_STRONG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WEAK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERS       = 2'd2;

  localparam logic [GAIN_W-1:0] INIT_STRONG_RST = 16'd26214;
  localparam logic [GAIN_W-1:0] INIT_WEAK_RST   = 16'd6554;
  localparam logic [ITER_W-1:0] ITERS_RST       = 6'd10;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              batch_end;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]        user_index;
    logic              is_strong;
    logic [6:0]        strong_count;
    logic [GAIN_W-1:0] strong_centroid;
    logic [GAIN_W-1:0] weak_centroid;
    logic              last_result;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  function automatic logic [GAIN_W-1:0] abs_diff(logic [GAIN_W-1:0] a,
                                                  logic [GAIN_W-1:0] b);
    logic [GAIN_W-1:0] r;
    r = (a >= b) ? (a - b) : (b - a);
    return r;
  endfunction

endpackage

### rtl/tckm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module tckm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/two_cluster_kmeans_1d_core.sv
// Operation: a gain beat is taken only while idle. A batch of n stored gains and P passes
// then clusters, each pass running n reads, the scan pipeline, a decision and the divider,
// and then sweeps out its results, held back by any output stalls.
// Throughput: input is stalled from the batch_end beat until the last result is loaded.
// Reset: asynchronous, active low; clears the control state and the store's fill count and
// restores the configuration registers to 0.8, 0.2 and ten passes.
module two_cluster_kmeans_1d_core #(
  parameter int unsigned MAX_USERS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  tckm_pkg::in_beat_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output tckm_pkg::out_beat_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [tckm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [tckm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  // Address width of the stores and width of a count that can hold MAX_USERS itself.
  localparam int unsigned IDX_W = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_USERS + 1);
  localparam int unsigned GW    = tckm_pkg::GAIN_W;
  localparam int unsigned SW    = tckm_pkg::SUM_W;

  // Configuration registers. They are only sampled when a batch starts clustering.
  logic [GW-1:0]                 cfg_strong_q;
  logic [GW-1:0]                 cfg_weak_q;
  logic [tckm_pkg::ITER_W-1:0]   cfg_iters_q;

  tckm_pkg::state_e state_q, state_d;

  // Fill count of the gain store; it also serves as the batch size n while clustering.
  logic [CNT_W-1:0] loaded_q, loaded_d;

  // Scan control: read issue counter and the two pipeline stages behind the RAM read.
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             rvalid_q, rvalid_d;
  logic [IDX_W-1:0] ridx_q;
  logic             a_valid_q, a_valid_d;
  logic [IDX_W-1:0] a_idx_q;
  logic [GW-1:0]    a_gain_q;
  logic             a_strong_q;

  // Per-pass accumulation and centroids.
  logic [SW-1:0]    ssum_q, wsum_q;
  logic [CNT_W-1:0] scnt_q, wcnt_q;
  logic [GW-1:0]    sc_q, wc_q;

  // Two restoring divider lanes; the dividend register shifts into the quotient.
  logic [SW-1:0]                   squo_q, wquo_q;
  logic [CNT_W-1:0]                srem_q, wrem_q;
  logic [tckm_pkg::DIV_STEP_W-1:0] div_step_q, div_step_d;

  logic [tckm_pkg::ITER_W-1:0] pass_left_q, pass_left_d;

  // Output sweep: j walks the mark store, want selects strong then weak, k counts results.
  logic [IDX_W-1:0] j_q, j_d;
  logic             want_q, want_d;
  logic [CNT_W-1:0] k_q, k_d;

  logic                out_valid_q, out_valid_d;
  tckm_pkg::out_beat_t out_q, out_d;

  // Strobes from the control logic to the datapath registers.
  logic batch_start, scan_start, div_start, div_run, div_finish, out_load;

  logic            in_acc;
  logic            store_we;
  logic [GW-1:0]   gain_rdata;
  logic            mark_rdata;
  logic            scan_done;
  logic            out_free;
  logic            strong_pick;

  // Divider step of each lane.
  logic [CNT_W:0]   s_trial, w_trial;
  logic             s_ge, w_ge;
  logic [CNT_W-1:0] srem_nx, wrem_nx;

  assign in_stall_o  = (state_q != tckm_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign store_we    = in_acc && (loaded_q < CNT_W'(MAX_USERS));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // The gain store is written only while idle and read only while scanning, and the mark
  // store is written only while scanning and read only while sweeping out, so the phases of
  // the sequencer keep every read clear of a pending write to the same entry.
  tckm_ram #(
    .WIDTH (GW),
    .DEPTH (MAX_USERS)
  ) u_gain_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (loaded_q[IDX_W-1:0]),
    .wdata_i (in_data_i.gain),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (gain_rdata)
  );

  // The mark store is addressed with the next sweep index, so its read data always belongs
  // to the entry that j_q points at.
  tckm_ram #(
    .WIDTH (1),
    .DEPTH (MAX_USERS)
  ) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (a_valid_q),
    .waddr_i (a_idx_q),
    .wdata_i (a_strong_q),
    .raddr_i (j_d),
    .rdata_o (mark_rdata)
  );

  // A gain joins the strong cluster only when strictly nearer the strong centroid.
  assign strong_pick = tckm_pkg::abs_diff(gain_rdata, sc_q) <
                       tckm_pkg::abs_diff(gain_rdata, wc_q);

  assign scan_done = (issue_q == loaded_q) && !rvalid_q && !a_valid_q;

  always_comb begin
    s_trial = {srem_q, squo_q[SW-1]};
    w_trial = {wrem_q, wquo_q[SW-1]};
    s_ge    = s_trial >= {1'b0, scnt_q};
    w_ge    = w_trial >= {1'b0, wcnt_q};
    srem_nx = s_ge ? CNT_W'(s_trial - {1'b0, scnt_q}) : CNT_W'(s_trial);
    wrem_nx = w_ge ? CNT_W'(w_trial - {1'b0, wcnt_q}) : CNT_W'(w_trial);
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    issue_d     = issue_q;
    rvalid_d    = 1'b0;
    a_valid_d   = rvalid_q;
    div_step_d  = div_step_q;
    pass_left_d = pass_left_q;
    j_d         = j_q;
    want_d      = want_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    batch_start = 1'b0;
    scan_start  = 1'b0;
    div_start   = 1'b0;
    div_run     = 1'b0;
    div_finish  = 1'b0;
    out_load    = 1'b0;

    unique case (state_q)
      tckm_pkg::S_IDLE: begin
        if (in_acc) begin
          if (store_we) begin
            loaded_d = loaded_q + CNT_W'(1);
          end
          if (in_data_i.batch_end) begin
            batch_start = 1'b1;
            scan_start  = 1'b1;
            issue_d     = '0;
            pass_left_d = (cfg_iters_q == '0) ? tckm_pkg::ITER_W'(1) : cfg_iters_q;
            state_d     = tckm_pkg::S_SCAN;
          end
        end
      end
      tckm_pkg::S_SCAN: begin
        if (issue_q != loaded_q) begin
          rvalid_d = 1'b1;
          issue_d  = issue_q + CNT_W'(1);
        end
        if (scan_done) begin
          div_start  = 1'b1;
          div_step_d = '0;
          state_d    = tckm_pkg::S_DIV;
        end
      end
      tckm_pkg::S_DIV: begin
        if (div_step_q != tckm_pkg::DIV_STEP_W'(SW)) begin
          div_run    = 1'b1;
          div_step_d = div_step_q + tckm_pkg::DIV_STEP_W'(1);
        end else begin
          div_finish = 1'b1;
          if (pass_left_q == tckm_pkg::ITER_W'(1)) begin
            j_d     = '0;
            want_d  = 1'b1;
            k_d     = '0;
            state_d = tckm_pkg::S_OUT;
          end else begin
            pass_left_d = pass_left_q - tckm_pkg::ITER_W'(1);
            scan_start  = 1'b1;
            issue_d     = '0;
            state_d     = tckm_pkg::S_SCAN;
          end
        end
      end
      tckm_pkg::S_OUT: begin
        if ((mark_rdata != want_q) || out_free) begin
          if (mark_rdata == want_q) begin
            out_load    = 1'b1;
            out_valid_d = 1'b1;
            k_d         = k_q + CNT_W'(1);
          end
          if (out_load && (k_q == (loaded_q - CNT_W'(1)))) begin
            // The final result now sits in the output register, so the batch closes here
            // even if entries of the other cluster remain to be skipped.
            j_d      = '0;
            loaded_d = '0;
            state_d  = tckm_pkg::S_IDLE;
          end else if (j_q == IDX_W'(loaded_q - CNT_W'(1))) begin
            j_d = '0;
            if (want_q) begin
              want_d = 1'b0;
            end else begin
              loaded_d = '0;
              state_d  = tckm_pkg::S_IDLE;
            end
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = tckm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d                 = out_q;
    out_d.user_index      = 6'(j_q);
    out_d.is_strong       = want_q;
    out_d.strong_count    = 7'(scnt_q);
    out_d.strong_centroid = sc_q;
    out_d.weak_centroid   = wc_q;
    out_d.last_result     = (k_q == (loaded_q - CNT_W'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_strong_q <= tckm_pkg::INIT_STRONG_RST;
      cfg_weak_q   <= tckm_pkg::INIT_WEAK_RST;
      cfg_iters_q  <= tckm_pkg::ITERS_RST;
      state_q      <= tckm_pkg::S_IDLE;
      loaded_q     <= '0;
      issue_q      <= '0;
      rvalid_q     <= 1'b0;
      a_valid_q    <= 1'b0;
      div_step_q   <= '0;
      pass_left_q  <= '0;
      j_q          <= '0;
      want_q       <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tckm_pkg::CFG_INIT_STRONG: cfg_strong_q <= cfg_wdata_i;
          tckm_pkg::CFG_INIT_WEAK:   cfg_weak_q   <= cfg_wdata_i;
          tckm_pkg::CFG_ITERS:       cfg_iters_q  <= cfg_wdata_i[tckm_pkg::ITER_W-1:0];
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      loaded_q    <= loaded_d;
      issue_q     <= issue_d;
      rvalid_q    <= rvalid_d;
      a_valid_q   <= a_valid_d;
      div_step_q  <= div_step_d;
      pass_left_q <= pass_left_d;
      j_q         <= j_d;
      want_q      <= want_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers; no reset, every value is written before it is used.
  always_ff @(posedge clk_i) begin
    ridx_q     <= issue_q[IDX_W-1:0];
    a_idx_q    <= ridx_q;
    a_gain_q   <= gain_rdata;
    a_strong_q <= strong_pick;

    if (batch_start) begin
      sc_q <= cfg_strong_q;
      wc_q <= cfg_weak_q;
    end else if (div_finish) begin
      if (scnt_q != '0) begin
        sc_q <= squo_q[GW-1:0];
      end
      if (wcnt_q != '0) begin
        wc_q <= wquo_q[GW-1:0];
      end
    end

    if (scan_start) begin
      ssum_q <= '0;
      wsum_q <= '0;
      scnt_q <= '0;
      wcnt_q <= '0;
    end else if (a_valid_q) begin
      if (a_strong_q) begin
        ssum_q <= ssum_q + SW'(a_gain_q);
        scnt_q <= scnt_q + CNT_W'(1);
      end else begin
        wsum_q <= wsum_q + SW'(a_gain_q);
        wcnt_q <= wcnt_q + CNT_W'(1);
      end
    end

    if (div_start) begin
      squo_q <= ssum_q;
      wquo_q <= wsum_q;
      srem_q <= '0;
      wrem_q <= '0;
    end else if (div_run) begin
      squo_q <= {squo_q[SW-2:0], s_ge};
      wquo_q <= {wquo_q[SW-2:0], w_ge};
      srem_q <= srem_nx;
      wrem_q <= wrem_nx;
    end

    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Every stored gain is counted exactly once in a pass.
  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tckm_pkg::S_SCAN && scan_done) |-> (scnt_q + wcnt_q == loaded_q))
    else $error("cluster counts do not add up to the batch size");

  // The sweep never emits more results than there are stored gains.
  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tckm_pkg::S_OUT) |-> (k_q < loaded_q))
    else $error("more results than stored gains");

  // No scan beat is in flight while idle or sweeping out.
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tckm_pkg::S_IDLE || state_q == tckm_pkg::S_OUT) |-> (!rvalid_q && !a_valid_q))
    else $error("scan pipeline active outside a pass");

  // The batch closes right after the final result is loaded.
  a_last_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last_result) |=> (state_q == tckm_pkg::S_IDLE && loaded_q == '0))
    else $error("batch did not close after its final result");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for two_cluster_kmeans_1d_core: directed and random gain batches.
// Depends on tckm_pkg and the core RTL only.
module testbench;

  localparam int unsigned MAX_USERS = 64;
  // No register sits at this index, so a write to it must change nothing.
  localparam logic [tckm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  // Cycles without any accepted beat before the run is declared hung. The slowest
  // legal batch (64 gains, 63 passes) clusters for well under this limit.
  localparam int unsigned QUIET_LIMIT = 30000;
  localparam int unsigned RANDOM_BEATS = 270;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  tckm_pkg::in_beat_t   in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  tckm_pkg::out_beat_t  out_data_o;
  logic                 cfg_we_i;
  logic [tckm_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [tckm_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  two_cluster_kmeans_1d_core #(.MAX_USERS(MAX_USERS)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the block: the gains held for the current batch and the three
  // registers. The registers are only sampled when a batch closes.
  logic [tckm_pkg::GAIN_W-1:0] gain_mem [MAX_USERS];
  int unsigned                 gains_held = 0;
  logic [tckm_pkg::GAIN_W-1:0] shadow_strong = tckm_pkg::INIT_STRONG_RST;
  logic [tckm_pkg::GAIN_W-1:0] shadow_weak = tckm_pkg::INIT_WEAK_RST;
  logic [tckm_pkg::ITER_W-1:0] shadow_passes = tckm_pkg::ITERS_RST;

  // Result beats the block still owes us, oldest first.
  tckm_pkg::out_beat_t owed_members [$];
  int unsigned mismatches = 0;
  int unsigned random_beats = 0;
  // When set, neither side inserts idle cycles.
  bit          steady = 1'b0;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned pause_len();
    if (steady || $urandom_range(0, 3) == 0) begin
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic int unsigned gain_distance(input int unsigned a, input int unsigned b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Runs the two-means passes over the held gains and queues one result beat per
  // held user: strong members in arrival order first, then weak members.
  function automatic void cluster_batch();
    int unsigned                 n;
    int unsigned                 passes;
    int unsigned                 s_n;
    int unsigned                 w_n;
    int unsigned                 k;
    logic [tckm_pkg::SUM_W-1:0]  s_sum;
    logic [tckm_pkg::SUM_W-1:0]  w_sum;
    logic [tckm_pkg::GAIN_W-1:0] s_c;
    logic [tckm_pkg::GAIN_W-1:0] w_c;
    bit                          strong_mark [MAX_USERS];
    tckm_pkg::out_beat_t         b;
    n = gains_held;
    // A pass count of zero still runs one pass.
    passes = (shadow_passes == 0) ? 1 : 32'(shadow_passes);
    s_c = shadow_strong;
    w_c = shadow_weak;
    s_n = 0;
    for (int p = 0; p < passes; p++) begin
      s_n = 0;
      w_n = 0;
      s_sum = '0;
      w_sum = '0;
      for (int i = 0; i < n; i++) begin
        // Strictly nearer the strong centroid, otherwise weak: ties go weak.
        if (gain_distance(32'(gain_mem[i]), 32'(s_c)) <
            gain_distance(32'(gain_mem[i]), 32'(w_c))) begin
          strong_mark[i] = 1'b1;
          s_sum = s_sum + tckm_pkg::SUM_W'(gain_mem[i]);
          s_n++;
        end else begin
          strong_mark[i] = 1'b0;
          w_sum = w_sum + tckm_pkg::SUM_W'(gain_mem[i]);
          w_n++;
        end
      end
      // An empty cluster keeps its centroid.
      if (s_n != 0) begin
        s_c = tckm_pkg::GAIN_W'(s_sum / s_n);
      end
      if (w_n != 0) begin
        w_c = tckm_pkg::GAIN_W'(w_sum / w_n);
      end
    end
    k = 0;
    for (int side = 1; side >= 0; side--) begin
      for (int i = 0; i < n; i++) begin
        if (strong_mark[i] == side[0]) begin
          b.user_index      = 6'(i);
          b.is_strong       = side[0];
          b.strong_count    = 7'(s_n);
          b.strong_centroid = s_c;
          b.weak_centroid   = w_c;
          b.last_result     = (k + 1 == n);
          owed_members      = {owed_members, b};
          k++;
        end
      end
    end
    gains_held = 0;
  endfunction

  // Offers one gain beat after a random gap and returns at the edge where it is taken.
  // Valid stays high on return so that back-to-back beats need no second assignment.
  task automatic send_gain(input logic [tckm_pkg::GAIN_W-1:0] g, input bit last);
    int unsigned        gap;
    tckm_pkg::in_beat_t b;
    gap = pause_len();
    b.gain = g;
    b.batch_end = last;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // A full store drops the gain, but its batch_end still closes the batch.
    if (gains_held < MAX_USERS) begin
      gain_mem[gains_held] = g;
      gains_held++;
    end
    if (last) begin
      cluster_batch();
    end
  endtask

  // Brings the block to rest: input idle, every owed beat received, and a few
  // cycles more so the core has left its output state.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (owed_members.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // One register write; the enable drops again on the following cycle.
  task automatic write_reg(input logic [tckm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tckm_pkg::CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      tckm_pkg::CFG_INIT_STRONG: shadow_strong = v;
      tckm_pkg::CFG_INIT_WEAK:   shadow_weak = v;
      tckm_pkg::CFG_ITERS:       shadow_passes = v[tckm_pkg::ITER_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly gains scattered around two levels, which is what a real channel
  // snapshot looks like, plus uniform noise, gains above 1.0 and exact ties.
  function automatic logic [tckm_pkg::GAIN_W-1:0] pick_gain(input int lo_lvl,
                                                            input int hi_lvl,
                                                            input int spread);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      v = ((r % 2) ? hi_lvl : lo_lvl) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return tckm_pkg::GAIN_W'(v);
    end else if (r < 85) begin
      return tckm_pkg::GAIN_W'($urandom_range(0, 32768));
    end else if (r < 95) begin
      return tckm_pkg::GAIN_W'($urandom_range(0, 65535));
    end
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 16'd32768;
      2: return 16'hFFFF;
      default: return tckm_pkg::GAIN_W'((int'(shadow_strong) + int'(shadow_weak)) / 2);
    endcase
  endfunction

  // Receiver: before each beat it holds stall high for a random number of cycles,
  // then waits with stall low until the block offers a beat.
  initial begin : result_sink
    int unsigned w;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      w = pause_len();
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  // Every accepted result beat is matched against the oldest owed one.
  always @(posedge clk_i) begin : result_check
    tckm_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_members.size() == 0) begin
        flag_mismatch($sformatf("result beat for user %0d with none owed",
                                out_data_o.user_index));
      end else begin
        want = owed_members.pop_front();
        check_field("user_index", 32'(out_data_o.user_index), 32'(want.user_index));
        check_field("is_strong", 32'(out_data_o.is_strong), 32'(want.is_strong));
        check_field("strong_count", 32'(out_data_o.strong_count),
                    32'(want.strong_count));
        check_field("strong_centroid", 32'(out_data_o.strong_centroid),
                    32'(want.strong_centroid));
        check_field("weak_centroid", 32'(out_data_o.weak_centroid),
                    32'(want.weak_centroid));
        check_field("last_result", 32'(out_data_o.last_result), 32'(want.last_result));
      end
    end
  end

  // Hang detection: a long run of cycles in which neither channel moves a beat.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  // Reset values of the registers: the midpoint gain ties and must go weak, and
  // gains of 0, 1.0 and above 1.0 sit at the ends of the range.
  task automatic test_default_registers();
    send_gain(16'd0, 1'b0);
    send_gain(16'd32768, 1'b0);
    send_gain(16'd16384, 1'b0);
    send_gain(16'hFFFF, 1'b0);
    send_gain(16'd26214, 1'b0);
    send_gain(16'd6554, 1'b1);
    settle();
  endtask

  // A batch of one user, and a batch in which every gain lands weak so the
  // strong centroid has no members and must stay where it started.
  task automatic test_degenerate_batches();
    send_gain(16'd20000, 1'b1);
    settle();
    send_gain(16'd1000, 1'b0);
    send_gain(16'd1000, 1'b0);
    send_gain(16'd1000, 1'b1);
    settle();
  endtask

  // Extreme register values: centroids at 0 and above 1.0, a pass count of zero,
  // a pass count written with all upper bits set, a write to the spare index,
  // and equal centroids so that every gain ties.
  task automatic test_register_extremes();
    write_reg(tckm_pkg::CFG_INIT_STRONG, 16'd0);
    write_reg(tckm_pkg::CFG_INIT_WEAK, 16'hFFFF);
    write_reg(tckm_pkg::CFG_ITERS, 16'd0);
    send_gain(16'd0, 1'b0);
    send_gain(16'hFFFF, 1'b0);
    send_gain(16'd32768, 1'b0);
    send_gain(16'd12345, 1'b1);
    settle();
    write_reg(CFG_SPARE, 16'h1234);
    write_reg(tckm_pkg::CFG_INIT_STRONG, 16'd32768);
    write_reg(tckm_pkg::CFG_INIT_WEAK, 16'd0);
    write_reg(tckm_pkg::CFG_ITERS, 16'hFFFF);
    send_gain(16'd32768, 1'b0);
    send_gain(16'd0, 1'b0);
    send_gain(16'd16384, 1'b0);
    send_gain(16'd40000, 1'b1);
    settle();
    write_reg(tckm_pkg::CFG_INIT_STRONG, 16'd16000);
    write_reg(tckm_pkg::CFG_INIT_WEAK, 16'd16000);
    write_reg(tckm_pkg::CFG_ITERS, 16'd1);
    send_gain(16'd100, 1'b0);
    send_gain(16'd30000, 1'b1);
    settle();
  endtask

  // A batch that fills the store exactly, then one that runs past it so the
  // tail gains, the closing one included, are dropped.
  task automatic test_store_overflow();
    write_reg(tckm_pkg::CFG_INIT_STRONG, tckm_pkg::INIT_STRONG_RST);
    write_reg(tckm_pkg::CFG_INIT_WEAK, tckm_pkg::INIT_WEAK_RST);
    write_reg(tckm_pkg::CFG_ITERS, 16'd3);
    steady = 1'b1;
    for (int i = 0; i < MAX_USERS; i++) begin
      send_gain(pick_gain(6000, 27000, 3000), i == MAX_USERS - 1);
      random_beats++;
    end
    steady = 1'b0;
    for (int i = 0; i < MAX_USERS + 3; i++) begin
      send_gain(pick_gain(9000, 24000, 6000), i == MAX_USERS + 2);
      random_beats++;
    end
    settle();
  endtask

  // Random batches with random content; now and then the registers are retuned
  // between batches, extremes included.
  task automatic test_random_batches();
    int unsigned len;
    int unsigned r;
    int unsigned passes;
    int          lo_lvl;
    int          hi_lvl;
    int          spread;
    logic [tckm_pkg::GAIN_W-1:0] c0;
    logic [tckm_pkg::GAIN_W-1:0] c1;
    while (random_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        c0 = tckm_pkg::GAIN_W'($urandom_range(16384, 32768));
        c1 = tckm_pkg::GAIN_W'($urandom_range(0, 16384));
        case ($urandom_range(0, 9))
          6, 7: begin
            // Strong register below the weak one.
            write_reg(tckm_pkg::CFG_INIT_STRONG, c1);
            write_reg(tckm_pkg::CFG_INIT_WEAK, c0);
          end
          8: begin
            write_reg(tckm_pkg::CFG_INIT_STRONG, c0);
            write_reg(tckm_pkg::CFG_INIT_WEAK, c0);
          end
          9: begin
            write_reg(tckm_pkg::CFG_INIT_STRONG,
                      $urandom_range(0, 1) ? 16'hFFFF : 16'd32768);
            write_reg(tckm_pkg::CFG_INIT_WEAK, 16'd0);
          end
          default: begin
            write_reg(tckm_pkg::CFG_INIT_STRONG, c0);
            write_reg(tckm_pkg::CFG_INIT_WEAK, c1);
          end
        endcase
        r = $urandom_range(0, 19);
        if (r < 14) passes = $urandom_range(1, 12);
        else if (r < 17) passes = $urandom_range(13, 63);
        else if (r < 19) passes = 0;
        else passes = 63;
        // Upper data bits are random; only the low six bits count.
        write_reg(tckm_pkg::CFG_ITERS, {10'($urandom_range(0, 1023)), 6'(passes)});
        if ($urandom_range(0, 7) == 0) begin
          write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
        end
      end
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 19);
      if (r < 16) len = $urandom_range(1, 10);
      else if (r < 19) len = $urandom_range(11, 40);
      else len = $urandom_range(41, MAX_USERS);
      lo_lvl = $urandom_range(0, 16384);
      hi_lvl = $urandom_range(16384, 32768);
      spread = $urandom_range(0, 4000);
      for (int i = 0; i < len; i++) begin
        send_gain(pick_gain(lo_lvl, hi_lvl, spread), i == len - 1);
        random_beats++;
      end
    end
    steady = 1'b0;
    settle();
  endtask

  initial begin : main
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= tckm_pkg::CFG_INIT_STRONG;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_registers();
    test_degenerate_batches();
    test_register_extremes();
    test_store_overflow();
    test_random_batches();

    // Let any stray beat show up before judging the run.
    while (owed_members.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && owed_members.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
